### src/sle_pkg.sv
// Shared opcodes, status codes and the command/status bundles that pass
// between the list controller and the list datapath. No dependencies.
`timescale 1ns / 1ps

package sle_pkg;

    // Command opcodes
    localparam logic [2:0] OP_INS_FRONT = 3'd0;
    localparam logic [2:0] OP_INS_BACK  = 3'd1;
    localparam logic [2:0] OP_INS_AT    = 3'd2;
    localparam logic [2:0] OP_RM_FRONT  = 3'd3;
    localparam logic [2:0] OP_RM_BACK   = 3'd4;
    localparam logic [2:0] OP_RM_AT     = 3'd5;
    localparam logic [2:0] OP_SEARCH    = 3'd6;

    // Result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;
    localparam logic [1:0] ST_BAD_POS = 2'd3;

    // Controller -> datapath commands
    typedef struct packed {
        logic load;      // capture a command beat and precompute target
        logic rd_up;     // read ptr-1 for an upward shift, ptr--
        logic rd_dn;     // read ptr for a downward shift, ptr++
        logic rd_srch;   // read ptr for a compare, ptr++
        logic wr_key;    // write the new word at the target index
        logic cnt_inc;
        logic cnt_dec;
        logic out_load;  // move the result into the output register
    } dp_cmd_t;

    // Datapath -> controller status
    typedef struct packed {
        logic err;       // captured command already has an error status
        logic is_ins;
        logic is_rm;
        logic is_srch;
        logic up_end;    // upward shift has read down to the target
        logic lim;       // pointer reached the entry count
        logic pend;      // a read is in flight
        logic hit;       // search found a match
        logic out_busy;  // output register full and stalled
    } dp_stat_t;

endpackage

### src/sle_datapath.sv
// List datapath: entry memory, count, pointers, search compare and the
// output register. Depends on sle_pkg.
`timescale 1ns / 1ps

module sle_datapath #(
    parameter int DEPTH      = 128,
    parameter int DATA_WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  sle_pkg::dp_cmd_t   cmd,
    output sle_pkg::dp_stat_t  stat,
    input  logic [2:0]         opcode,
    input  logic [7:0]         position,
    input  logic signed [31:0] value,
    input  logic               out_stall,
    output logic               out_valid,
    output logic [1:0]         status,
    output logic               found,
    output logic [6:0]         match_index,
    output logic [7:0]         entry_count
);
    import sle_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > 8) ? CW : 8;

    // Entry memory, one write and one registered read per cycle
    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;
    logic [AW-1:0]         rd_addr_reg;

    // Control registers
    logic [CW-1:0] count_reg, count_next;
    logic          pend_reg;
    logic          out_valid_reg, out_valid_next;

    // Command payload registers
    logic [2:0]            op_reg;
    logic [DATA_WIDTH-1:0] key_reg;
    logic [CW-1:0]         at_reg;
    logic [CW-1:0]         ptr_reg, ptr_next;
    logic [1:0]            status_reg;
    logic                  found_reg;
    logic [AW-1:0]         idx_reg;
    logic                  pend_up_reg;
    logic                  pend_cmp_reg;

    // Output register
    logic [1:0] out_status_reg;
    logic       out_found_reg;
    logic [6:0] out_index_reg;
    logic [7:0] out_count_reg;

    // Load-time decode
    logic [PW-1:0] pos_ext, cnt_ext;
    logic          pos_lt;
    logic [CW-1:0] pos_cw;
    logic [CW-1:0] ld_at, ld_ptr;
    logic [1:0]    ld_status;
    logic          op_ins, op_rm;

    // Memory port selection
    logic [CW-1:0]         ptr_dec;
    logic                  rd_en, wr_en;
    logic [AW-1:0]         rd_addr, wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;
    logic                  cmp_hit;

    assign pos_ext = PW'(position);
    assign cnt_ext = PW'(count_reg);
    assign pos_lt  = pos_ext < cnt_ext;
    assign pos_cw  = CW'(pos_ext);
    assign op_ins  = (opcode == OP_INS_FRONT) || (opcode == OP_INS_BACK)
                  || (opcode == OP_INS_AT);
    assign op_rm   = (opcode == OP_RM_FRONT) || (opcode == OP_RM_BACK)
                  || (opcode == OP_RM_AT);

    // Target index and starting pointer for the incoming command
    always_comb
    begin
        ld_at  = '0;
        ld_ptr = '0;
        unique case (opcode)
            OP_INS_FRONT:
            begin
                ld_at  = '0;
                ld_ptr = count_reg;
            end
            OP_INS_BACK:
            begin
                ld_at  = count_reg;
                ld_ptr = count_reg;
            end
            OP_INS_AT:
            begin
                ld_at  = pos_lt ? pos_cw : count_reg;
                ld_ptr = count_reg;
            end
            OP_RM_FRONT:
            begin
                ld_at  = '0;
                ld_ptr = CW'(1);
            end
            OP_RM_BACK:
            begin
                ld_at  = count_reg - CW'(1);
                ld_ptr = count_reg;
            end
            OP_RM_AT:
            begin
                ld_at  = pos_cw;
                ld_ptr = pos_cw + CW'(1);
            end
            default:
            begin
                ld_at  = '0;
                ld_ptr = '0;
            end
        endcase
    end

    // Error status; empty wins over a bad position
    always_comb
    begin
        ld_status = ST_OK;
        if (op_ins && (count_reg == CW'(DEPTH)))
            ld_status = ST_FULL;
        else if (op_rm && (count_reg == '0))
            ld_status = ST_EMPTY;
        else if ((opcode == OP_RM_AT) && !pos_lt)
            ld_status = ST_BAD_POS;
    end

    // Memory port muxing
    assign ptr_dec = ptr_reg - CW'(1);
    assign rd_en   = cmd.rd_up || cmd.rd_dn || cmd.rd_srch;
    assign rd_addr = cmd.rd_up ? ptr_dec[AW-1:0] : ptr_reg[AW-1:0];
    assign wr_en   = cmd.wr_key || (pend_reg && !pend_cmp_reg);
    assign wr_addr = cmd.wr_key ? at_reg[AW-1:0]
                   : (pend_up_reg ? rd_addr_reg + AW'(1) : rd_addr_reg - AW'(1));
    assign wr_data = cmd.wr_key ? key_reg : rd_data_reg;
    assign cmp_hit = pend_reg && pend_cmp_reg && !found_reg && (rd_data_reg == key_reg);

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    // Pointer next value
    always_comb
    begin
        ptr_next = ptr_reg;
        if (cmd.load)
            ptr_next = ld_ptr;
        else if (cmd.rd_up)
            ptr_next = ptr_dec;
        else if (cmd.rd_dn || cmd.rd_srch)
            ptr_next = ptr_reg + CW'(1);
    end

    // Count and output valid next values
    always_comb
    begin
        count_next = count_reg;
        if (cmd.cnt_inc)
            count_next = count_reg + CW'(1);
        else if (cmd.cnt_dec)
            count_next = count_reg - CW'(1);
    end

    assign out_valid_next = cmd.out_load || (out_valid_reg && out_stall);

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            pend_reg      <= rd_en;
            out_valid_reg <= out_valid_next;
        end
    end

    // Command payload and search tracking
    always_ff @(posedge clk)
    begin
        ptr_reg <= ptr_next;
        if (rd_en)
        begin
            rd_addr_reg  <= rd_addr;
            pend_up_reg  <= cmd.rd_up;
            pend_cmp_reg <= cmd.rd_srch;
        end
        if (cmd.load)
        begin
            op_reg     <= opcode;
            key_reg    <= DATA_WIDTH'($unsigned(value));
            at_reg     <= ld_at;
            status_reg <= ld_status;
            found_reg  <= 1'b0;
            idx_reg    <= '0;
        end
        else if (cmp_hit)
        begin
            found_reg <= 1'b1;
            idx_reg   <= rd_addr_reg;
        end
        if (cmd.out_load)
        begin
            out_status_reg <= status_reg;
            out_found_reg  <= found_reg;
            out_index_reg  <= 7'(idx_reg);
            out_count_reg  <= 8'(count_reg);
        end
    end

    // Status to controller
    assign stat.err      = (status_reg != ST_OK);
    assign stat.is_ins   = (op_reg == OP_INS_FRONT) || (op_reg == OP_INS_BACK)
                        || (op_reg == OP_INS_AT);
    assign stat.is_rm    = (op_reg == OP_RM_FRONT) || (op_reg == OP_RM_BACK)
                        || (op_reg == OP_RM_AT);
    assign stat.is_srch  = (op_reg == OP_SEARCH);
    assign stat.up_end   = (ptr_reg == at_reg);
    assign stat.lim      = (ptr_reg >= count_reg);
    assign stat.pend     = pend_reg;
    assign stat.hit      = found_reg;
    assign stat.out_busy = out_valid_reg && out_stall;

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign found       = out_found_reg;
    assign match_index = out_index_reg;
    assign entry_count = out_count_reg;

endmodule

### src/sle_controller.sv
// List controller: state machine that sequences shifts, searches and the
// result beat. Depends on sle_pkg.
`timescale 1ns / 1ps

module sle_controller (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  sle_pkg::dp_stat_t stat,
    output sle_pkg::dp_cmd_t  cmd
);
    import sle_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_DISPATCH = 6'b000010,
        S_UP       = 6'b000100,
        S_DN       = 6'b001000,
        S_SRCH     = 6'b010000,
        S_DONE     = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // Next state and command decode
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (stat.err)
                    state_next = S_DONE;
                else if (stat.is_ins)
                    state_next = S_UP;
                else if (stat.is_rm)
                    state_next = S_DN;
                else if (stat.is_srch)
                    state_next = S_SRCH;
                else
                    state_next = S_DONE;
            end
            S_UP:
            begin
                // read from the top down to the target, then drop in the word
                if (!stat.up_end)
                    cmd.rd_up = 1'b1;
                else if (!stat.pend)
                begin
                    cmd.wr_key  = 1'b1;
                    cmd.cnt_inc = 1'b1;
                    state_next  = S_DONE;
                end
            end
            S_DN:
            begin
                // pull each entry above the target down by one
                if (!stat.lim)
                    cmd.rd_dn = 1'b1;
                else if (!stat.pend)
                begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = S_DONE;
                end
            end
            S_SRCH:
            begin
                if (!stat.lim && !stat.hit)
                    cmd.rd_srch = 1'b1;
                else if (!stat.pend)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!stat.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

### src/sequential_list_engine.sv
// Top level of the list engine: controller plus datapath.
// Depends on sle_pkg, sle_controller and sle_datapath.
`timescale 1ns / 1ps

// Ordered list of up to DEPTH words held in a simple dual-port entry memory (one
// write, one registered read per cycle). One command is in flight at a time;
// a new command beat is taken while the previous result still waits on the
// output. The time from command beat to out_valid rising is set by the shift
// or scan loop over that memory port: an insert at index p moves each entry
// from the top down to p up by one, then writes the word at p; a removal at p
// pulls each entry above p down by one; a search reads from index 0 up to the
// first match or the end of the list; and a command rejected as full, empty or
// bad position goes straight to its result. Entry contents are undefined after
// reset; no clearing pass is run.
module sequential_list_engine #(
    parameter int DEPTH      = 128,
    parameter int DATA_WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         opcode,
    input  logic [7:0]         position,
    input  logic signed [31:0] value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         status,
    output logic               found,
    output logic [6:0]         match_index,
    output logic [7:0]         entry_count
);
    import sle_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    sle_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    sle_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .opcode      (opcode),
        .position    (position),
        .value       (value),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .status      (status),
        .found       (found),
        .match_index (match_index),
        .entry_count (entry_count)
    );

endmodule

### src/sle_checker.sv
// Port-level checks for the list engine, bound onto the top level.
// Depends on sle_pkg and sequential_list_engine.
`timescale 1ns / 1ps

module sle_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  status,
    input logic        found,
    input logic [6:0]  match_index,
    input logic [7:0]  entry_count
);
    import sle_pkg::*;

    // one command at a time: a taken beat closes the input
    a_accept_closes: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input open right after a command beat");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(found)
            && $stable(match_index) && $stable(entry_count))
        else $error("stalled result changed");

    // a match only comes with an ok status
    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && found |-> status == ST_OK)
        else $error("found with error status");

    // no match means a zero index
    a_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> match_index == 7'd0)
        else $error("nonzero index without a match");

endmodule

bind sequential_list_engine sle_checker u_sle_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .found       (found),
    .match_index (match_index),
    .entry_count (entry_count)
);
